/* sv/lirs_pkg.sv */
// ----------------------------------------------------------------------------
// Linear-interpolation resampler package
// Shared widths, constants, controller states and the command and status
// structures that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package lirs_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned STEP_W   = 32;
  localparam int unsigned FRAC_W   = 24;
  localparam int unsigned POS_W    = 33;

  // Unsigned Q8.24 step limits: 1/32 at the low end, 44100/48000 out of reset.
  localparam logic [STEP_W-1:0] STEP_MIN   = 32'd524288;
  localparam logic [STEP_W-1:0] STEP_RESET = 32'd15414067;

  localparam logic [POS_W-1:0] POS_ONE = 33'h0_0100_0000;

  // Register index of the rate step within the configuration map.
  localparam logic REG_RATE_STEP = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EMIT
  } lirs_state_e;

  typedef struct packed {
    logic accept;        // latch the incoming frame and its batch-end flag
    logic load_held_in;  // held frame taken straight from the input
    logic load_held_new; // held frame taken from the latched new frame
    logic set_valid;
    logic clr_valid;
    logic sub_one;       // position minus one at the end of an interval
    logic mul;           // form the interpolation products
    logic emit;          // round, load the output register, advance position
    logic phase_b;       // working on the interval after a batch-end frame
  } lirs_cmd_t;

  typedef struct packed {
    logic held_valid;
    logic batch_end;
    logic pos_ge_one;
    logic out_free;
  } lirs_sts_t;

endpackage

/* sv/lirs_ctrl.sv */
// ----------------------------------------------------------------------------
// Linear-interpolation resampler controller
// Sequences the intervals of one input frame: accept, position checks,
// product and emission cycles, and the interval that closes a batch.
// ----------------------------------------------------------------------------
module lirs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_batch_end_i,
  output logic                in_ready_o,
  input  lirs_pkg::lirs_sts_t sts_i,
  output lirs_pkg::lirs_cmd_t cmd_o
);

  lirs_pkg::lirs_state_e state_q, state_d;
  logic                  phase_b_q, phase_b_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lirs_pkg::ST_IDLE;
      phase_b_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_b_q <= phase_b_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    phase_b_d  = phase_b_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.phase_b = phase_b_q;

    case (state_q)
      lirs_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.held_valid) begin
            phase_b_d = 1'b0;
            state_d   = lirs_pkg::ST_CHECK;
          end else begin
            // First frame of a batch: only stored, unless it also ends it.
            cmd_o.load_held_in = 1'b1;
            if (in_batch_end_i) begin
              phase_b_d = 1'b1;
              state_d   = lirs_pkg::ST_CHECK;
            end else begin
              cmd_o.set_valid = 1'b1;
            end
          end
        end
      end

      lirs_pkg::ST_CHECK: begin
        if (sts_i.pos_ge_one) begin
          cmd_o.sub_one = 1'b1;
          if (!phase_b_q) begin
            cmd_o.load_held_new = 1'b1;
            if (sts_i.batch_end) begin
              phase_b_d = 1'b1;
            end else begin
              cmd_o.set_valid = 1'b1;
              state_d         = lirs_pkg::ST_IDLE;
            end
          end else begin
            cmd_o.clr_valid = 1'b1;
            state_d         = lirs_pkg::ST_IDLE;
          end
        end else begin
          cmd_o.mul = 1'b1;
          state_d   = lirs_pkg::ST_EMIT;
        end
      end

      lirs_pkg::ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = lirs_pkg::ST_CHECK;
        end
      end

      default: begin
        state_d = lirs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* sv/lirs_dp.sv */
// ----------------------------------------------------------------------------
// Linear-interpolation resampler datapath
// Held and new frames, the Q9.24 read position, the two interpolation
// multipliers with their product registers, rounding and the output register.
// ----------------------------------------------------------------------------
module lirs_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  lirs_pkg::lirs_cmd_t                    cmd_i,
  output lirs_pkg::lirs_sts_t                    sts_o,
  input  logic                                   pos_clear_i,
  input  logic        [lirs_pkg::STEP_W-1:0]     step_i,
  input  logic signed [lirs_pkg::SAMPLE_W-1:0]   in_left_i,
  input  logic signed [lirs_pkg::SAMPLE_W-1:0]   in_right_i,
  input  logic                                   in_batch_end_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [lirs_pkg::SAMPLE_W-1:0]   out_left_o,
  output logic signed [lirs_pkg::SAMPLE_W-1:0]   out_right_o,
  output logic                                   out_last_o
);

  localparam int unsigned SW   = lirs_pkg::SAMPLE_W;
  localparam int unsigned FW   = lirs_pkg::FRAC_W;
  localparam int unsigned PW   = lirs_pkg::POS_W;
  localparam int unsigned PRW  = SW + 1 + FW + 1;  // difference times fraction
  localparam int unsigned VW   = PRW + 1;          // plus scaled held sample

  localparam logic signed [VW-1:0] HALF_UP   = VW'(1) <<< (FW - 1);
  localparam logic signed [VW-1:0] HALF_DOWN = HALF_UP - VW'(1);

  logic signed [SW-1:0]  held_l_q, held_r_q;
  logic signed [SW-1:0]  new_l_q, new_r_q;
  logic                  held_valid_q;
  logic                  batch_end_q;
  logic        [PW-1:0]  pos_q;
  logic signed [PRW-1:0] prod_l_q, prod_r_q;
  logic                  out_valid_q, out_last_q;
  logic signed [SW-1:0]  out_l_q, out_r_q;

  logic        [PW-1:0]  pos_next;
  logic signed [SW:0]    diff_l, diff_r;
  logic signed [FW:0]    frac_s;
  logic signed [VW-1:0]  v_l, v_r;
  logic                  last_flag;

  function automatic logic signed [SW-1:0] round_q24(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] r;
    // Half away from zero: negative values take one less than a half.
    r = v + (v[VW-1] ? HALF_DOWN : HALF_UP);
    return r[FW +: SW];
  endfunction

  assign pos_next = pos_q + PW'(step_i);
  assign frac_s   = $signed({1'b0, pos_q[FW-1:0]});
  assign diff_l   = (SW+1)'(new_l_q) - (SW+1)'(held_l_q);
  assign diff_r   = (SW+1)'(new_r_q) - (SW+1)'(held_r_q);
  assign v_l      = (VW'(held_l_q) <<< FW) + VW'(prod_l_q);
  assign v_r      = (VW'(held_r_q) <<< FW) + VW'(prod_r_q);

  // The emission is the last of this frame when the next position leaves the
  // interval and no batch-end interval with emissions follows.
  always_comb begin
    last_flag = 1'b0;
    if (pos_next[PW-1:FW] != '0) begin
      if (cmd_i.phase_b || !batch_end_q) begin
        last_flag = 1'b1;
      end else begin
        last_flag = (pos_next[PW-1:FW+1] != '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_l_q     <= '0;
      held_r_q     <= '0;
      held_valid_q <= 1'b0;
      pos_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.load_held_in) begin
        held_l_q <= in_left_i;
        held_r_q <= in_right_i;
      end else if (cmd_i.load_held_new) begin
        held_l_q <= new_l_q;
        held_r_q <= new_r_q;
      end
      if (cmd_i.set_valid) begin
        held_valid_q <= 1'b1;
      end else if (cmd_i.clr_valid) begin
        held_valid_q <= 1'b0;
      end

      if (pos_clear_i) begin
        pos_q <= '0;
      end else if (cmd_i.sub_one) begin
        pos_q <= pos_q - lirs_pkg::POS_ONE;
      end else if (cmd_i.emit) begin
        pos_q <= pos_next;
      end

      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      new_l_q     <= in_left_i;
      new_r_q     <= in_right_i;
      batch_end_q <= in_batch_end_i;
    end
    if (cmd_i.mul) begin
      prod_l_q <= PRW'(diff_l * frac_s);
      prod_r_q <= PRW'(diff_r * frac_s);
    end
    if (cmd_i.emit) begin
      out_l_q    <= round_q24(v_l);
      out_r_q    <= round_q24(v_r);
      out_last_q <= last_flag;
    end
  end

  assign sts_o.held_valid = held_valid_q;
  assign sts_o.batch_end  = batch_end_q;
  assign sts_o.pos_ge_one = (pos_q[PW-1:FW] != '0);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_left_o  = out_l_q;
  assign out_right_o = out_r_q;
  assign out_last_o  = out_last_q;

endmodule

/* sv/linear_interp_resampler_unit.sv */
// ----------------------------------------------------------------------------
// Linear-interpolation resampler, top level
// Stereo 16-bit sample-rate converter with a Q8.24 rate step register.
// ----------------------------------------------------------------------------
// Usage:
//   Guest frames enter on the s_axis channel (left and right in tdata, tlast
//   marking the final frame of a batch); host frames leave on m_axis, with
//   tlast set on the last frame that an input transaction produces.
//   The rate step (guest over host rate, unsigned Q8.24) lies at APB address
//   0. Writes below 1/32 are raised to 1/32, and every write clears the read
//   position. Write it only while the block is idle.
//   Sequence: each output frame passes through the product registers, then
//   rounding and the output register, and each interval ends with a closing
//   position check. A frame gives at most 64 outputs; one that closes a batch
//   that an earlier frame opened also plays out its own interval.
//   The first frame of a batch is only stored, unless it also closes it.
//   The input is taken only between frames; a result waiting in the output
//   register does not block the next input transaction.
//   If the receiver stalls, the block holds its next result until the output
//   register is taken, then carries on.
//   Reset clears the held frame, its valid flag and the position, and loads
//   the step with 44100/48000.
// ----------------------------------------------------------------------------
module linear_interp_resampler_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] in_left, [31:16] in_right
  input  logic        s_axis_tlast,   // batch_end
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] out_left, [31:16] out_right
  output logic        m_axis_tlast,   // run_last
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [lirs_pkg::STEP_W-1:0] step_q;
  logic                        cfg_wr;
  logic                        step_sel;
  lirs_pkg::lirs_cmd_t         cmd;
  lirs_pkg::lirs_sts_t         sts;
  logic signed [lirs_pkg::SAMPLE_W-1:0] out_l, out_r;

  assign pready   = 1'b1;
  assign step_sel = (paddr[2] == lirs_pkg::REG_RATE_STEP);
  assign cfg_wr   = psel && penable && pwrite && pready && step_sel;
  assign prdata   = step_sel ? step_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= lirs_pkg::STEP_RESET;
    end else if (cfg_wr) begin
      step_q <= (pwdata < lirs_pkg::STEP_MIN) ? lirs_pkg::STEP_MIN : pwdata;
    end
  end

  lirs_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_batch_end_i(s_axis_tlast),
    .in_ready_o    (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  lirs_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .pos_clear_i   (cfg_wr),
    .step_i        (step_q),
    .in_left_i     ($signed(s_axis_tdata[15:0])),
    .in_right_i    ($signed(s_axis_tdata[31:16])),
    .in_batch_end_i(s_axis_tlast),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_left_o    (out_l),
    .out_right_o   (out_r),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {out_r, out_l};

endmodule

/* tb/lirs_frame_checker.sv */
// ----------------------------------------------------------------------------
// Resampler frame checker
// Watches the guest frame, host frame and configuration channels of the
// resampler. It keeps its own copy of the held frame, the read position and
// the rate step, works out the host frames that each accepted guest frame
// should produce, and compares every output transaction with the oldest one
// still due.
// ----------------------------------------------------------------------------
module lirs_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] in_left, [31:16] in_right
  input  logic        s_axis_tlast,   // batch_end
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // [15:0] out_left, [31:16] out_right
  input  logic        m_axis_tlast,   // run_last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SPAN_FRAMES = 64;

  typedef struct packed {
    logic [lirs_pkg::SAMPLE_W-1:0] left;
    logic [lirs_pkg::SAMPLE_W-1:0] right;
    logic                          run_last;
  } host_frame_t;

  host_frame_t                   frames_due[$];
  host_frame_t                   span_buf[MAX_SPAN_FRAMES];
  host_frame_t                   due;
  logic [lirs_pkg::STEP_W-1:0]   step_q;
  logic [lirs_pkg::POS_W-1:0]    pos_q;
  logic [lirs_pkg::SAMPLE_W-1:0] held_l;
  logic [lirs_pkg::SAMPLE_W-1:0] held_r;
  logic                          held_ok;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // Weighted sum in Q24, then rounded half away from zero.
  function automatic logic [lirs_pkg::SAMPLE_W-1:0] blend(
    input logic [lirs_pkg::SAMPLE_W-1:0] a,
    input logic [lirs_pkg::SAMPLE_W-1:0] b,
    input logic [lirs_pkg::FRAC_W-1:0]   frac
  );
    longint acc;
    longint mag;
    acc = longint'($signed(a)) * 64'sd16777216
        + (longint'($signed(b)) - longint'($signed(a))) * longint'(frac);
    if (acc >= 0) begin
      mag = (acc + 64'sd8388608) >>> lirs_pkg::FRAC_W;
    end else begin
      mag = -((-acc + 64'sd8388608) >>> lirs_pkg::FRAC_W);
    end
    return mag[lirs_pkg::SAMPLE_W-1:0];
  endfunction

  // One interval from the held frame towards the new one. A position at or
  // above one gives nothing and only loses one.
  task automatic run_span(input logic [lirs_pkg::SAMPLE_W-1:0] nl,
                          input logic [lirs_pkg::SAMPLE_W-1:0] nr,
                          inout int n);
    while (pos_q < lirs_pkg::POS_ONE && n < MAX_SPAN_FRAMES) begin
      span_buf[n].left     = blend(held_l, nl, pos_q[lirs_pkg::FRAC_W-1:0]);
      span_buf[n].right    = blend(held_r, nr, pos_q[lirs_pkg::FRAC_W-1:0]);
      span_buf[n].run_last = 1'b0;
      n++;
      pos_q = pos_q + {1'b0, step_q};
    end
    pos_q = pos_q - lirs_pkg::POS_ONE;
  endtask

  task automatic resample_frame(input logic [lirs_pkg::SAMPLE_W-1:0] nl,
                                input logic [lirs_pkg::SAMPLE_W-1:0] nr,
                                input logic closes);
    int n;
    n = 0;
    // The opening frame of a batch has nothing to interpolate from.
    if (held_ok) begin
      run_span(nl, nr, n);
    end
    held_l  = nl;
    held_r  = nr;
    held_ok = 1'b1;
    // A closing frame also plays out its own interval, unchanged.
    if (closes) begin
      run_span(nl, nr, n);
      held_ok = 1'b0;
    end
    if (n > 0) begin
      span_buf[n-1].run_last = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      frames_due.push_back(span_buf[i]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  = lirs_pkg::STEP_RESET;
      pos_q   = '0;
      held_l  = '0;
      held_r  = '0;
      held_ok = 1'b0;
      frames_due.delete();
    end else begin
      // Outputs are checked before new inputs so that a frame can never be
      // matched against the guest frame accepted at the same edge.
      if (m_axis_tvalid && m_axis_tready) begin
        if (frames_due.size() == 0) begin
          $error("host frame with nothing due: left %0d, right %0d, last %0b",
                 $signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[31:16]), m_axis_tlast);
          fail_count_o++;
        end else begin
          due = frames_due.pop_front();
          if (m_axis_tdata[15:0] !== due.left) begin
            $error("out_left mismatch: expected %0d, actual %0d",
                   $signed(due.left), $signed(m_axis_tdata[15:0]));
            fail_count_o++;
          end
          if (m_axis_tdata[31:16] !== due.right) begin
            $error("out_right mismatch: expected %0d, actual %0d",
                   $signed(due.right), $signed(m_axis_tdata[31:16]));
            fail_count_o++;
          end
          if (m_axis_tlast !== due.run_last) begin
            $error("run_last mismatch: expected %0b, actual %0b", due.run_last, m_axis_tlast);
            fail_count_o++;
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr[2] == lirs_pkg::REG_RATE_STEP) begin
        step_q = (pwdata < lirs_pkg::STEP_MIN) ? lirs_pkg::STEP_MIN : pwdata;
        pos_q  = '0;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        resample_frame(s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tlast);
      end
    end
    pending_o = frames_due.size();
  end

endmodule

/* tb/tb_linear_interp_resampler_unit.sv */
// ----------------------------------------------------------------------------
// Resampler testbench
// Drives guest frames in batches through the resampler under a range of rate
// steps, with random idle cycles on both channels and repeated long output stalls,
// and lets the frame checker judge every host frame that comes out.
// ----------------------------------------------------------------------------
module tb_linear_interp_resampler_unit;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0]  STEP_ADDR     = {lirs_pkg::REG_RATE_STEP, 2'b00};
  localparam logic [2:0]  SPARE_ADDR    = {~lirs_pkg::REG_RATE_STEP, 2'b00};
  localparam logic [31:0] STEP_UNITY    = 32'h0100_0000;
  localparam logic [31:0] STEP_TOP      = 32'hFFFF_FFFF;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned PHASE_FRAMES  = 48;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned STALL_CYCLES  = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;  // [15:0] in_left, [31:16] in_right
  logic        s_axis_tlast = 1'b0; // batch_end
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [15:0] out_left, [31:16] out_right
  logic        m_axis_tlast;        // run_last
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int          fail_count;
  int          pending;
  int unsigned frames_sent = 0;
  bit          send_eager = 1'b0;

  always #2 clk_i = ~clk_i;

  linear_interp_resampler_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  lirs_frame_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  function automatic logic [15:0] draw_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'($urandom_range(0, 8)) - 16'd4;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] draw_step();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, lirs_pkg::STEP_MIN - 1);
      1:       return $urandom_range(lirs_pkg::STEP_MIN, STEP_UNITY);
      2:       return $urandom_range(STEP_UNITY, 32'h0400_0000);
      3:       return $urandom;
      default: return $urandom_range(32'd12000000, 32'd20000000);
    endcase
  endfunction

  function automatic int unsigned draw_batch_len();
    case ($urandom_range(0, 9))
      0:       return 1;
      1:       return $urandom_range(24, 40);
      default: return $urandom_range(2, 12);
    endcase
  endfunction

  task automatic send_frame(input logic [15:0] left, input logic [15:0] right,
                            input logic last);
    int unsigned gap;
    gap = send_eager ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {right, left};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    frames_sent++;
  endtask

  task automatic send_batch(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_frame(draw_sample(), draw_sample(), i == len - 1);
    end
  endtask

  // Lets the block run dry: every host frame taken, then time for an interval
  // that produces nothing to finish.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    #3_000_000;
    $display("linear_interp_resampler_unit verification failed");
    $finish;
  end

  // Output side: random back-pressure, with eager stretches and a few long
  // holds that let the block back up into its input.
  initial begin
    int unsigned gap;
    int unsigned taken;
    bit          eager;
    taken = 0;
    eager = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (taken % 64 == 0) begin
        eager = ($urandom_range(0, 3) == 0);
      end
      if (taken == 300 || (taken != 0 && taken % 900 == 0)) begin
        gap = STALL_CYCLES;
      end else begin
        gap = eager ? 0 : $urandom_range(0, 3);
      end
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      taken++;
    end
  end

  initial begin
    int unsigned phase_start;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset step. A lone frame opens and closes its batch, so it only plays
    // out its own interval.
    send_frame(16'h0064, 16'hFF9C, 1'b1);
    send_frame(16'h8000, 16'h7FFF, 1'b0);
    send_frame(16'h7FFF, 16'h8000, 1'b0);
    send_frame(16'h0000, 16'hFFFF, 1'b0);
    send_frame(16'hFFFF, 16'h0000, 1'b0);
    send_frame(16'h7FFF, 16'h7FFF, 1'b0);
    send_frame(16'h8000, 16'h8000, 1'b1);

    // A zero step is raised to the 1/32 floor: full 32-frame intervals, and
    // steps of one across them hit exact halves in the rounding.
    settle();
    write_reg(STEP_ADDR, 32'd0);
    send_frame(16'h8000, 16'h7FFF, 1'b0);
    send_frame(16'h7FFF, 16'h8000, 1'b0);
    send_frame(16'h0000, 16'h0000, 1'b0);
    send_frame(16'h0001, 16'hFFFF, 1'b0);
    send_frame(16'h0000, 16'h0000, 1'b1);

    // A write outside the map must leave step and position alone.
    settle();
    write_reg(SPARE_ADDR, STEP_UNITY);
    send_frame(16'h0003, 16'hFFFD, 1'b0);
    send_frame(16'hFFFC, 16'h0004, 1'b1);

    settle();
    write_reg(STEP_ADDR, STEP_UNITY);
    send_frame(16'h1234, 16'hEDCB, 1'b0);
    send_frame(16'h8000, 16'h7FFF, 1'b0);
    send_frame(16'h0000, 16'h0001, 1'b1);

    // Largest step: after the first output the position stays above one for many
    // intervals, each giving nothing.
    settle();
    write_reg(STEP_ADDR, STEP_TOP);
    send_frame(16'h4000, 16'hC000, 1'b0);
    send_frame(16'h7FFF, 16'h8000, 1'b0);
    send_frame(16'h0000, 16'h0000, 1'b0);
    send_frame(16'hFFFF, 16'h0001, 1'b1);

    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      write_reg(STEP_ADDR, draw_step());
      phase_start = frames_sent;
      while (frames_sent - phase_start < PHASE_FRAMES) begin
        send_eager = ($urandom_range(0, 4) == 0);
        send_batch(draw_batch_len());
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("linear_interp_resampler_unit verification clean");
    end else begin
      $display("linear_interp_resampler_unit verification failed");
    end
    $finish;
  end

endmodule
